/* sv/fcr_pkg.sv */
// Package for the framed command receiver.
// Holds frame constants, event codes and the record passed from parser to executor.
// No dependencies.
`default_nettype none

package fcr_pkg;

  // Largest frame in bytes: start, command, length, payload, checksum.
  localparam int unsigned MAX_FRAME_BYTES = 24;
  localparam int unsigned HDR_BYTES       = 4;
  localparam int unsigned POS_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned LEN_W           = 5;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] CMD_MOVE   = 8'h01;
  localparam logic [7:0] CMD_HALT   = 8'h02;

  localparam logic [15:0] UPPER_RESET = 16'sd1500;
  localparam logic [15:0] LOWER_RESET = -16'sd1500;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_UPPER = 1'b0;
  localparam cfg_idx_t CFG_LOWER = 1'b1;

  typedef enum logic [2:0] {
    EV_MOVE    = 3'd0,
    EV_STOP    = 3'd1,
    EV_UNKNOWN = 3'd2,
    EV_SHORT   = 3'd3,
    EV_BADSUM  = 3'd4
  } event_e;

  // One completed frame as seen by the parser.
  typedef struct packed {
    logic             bad_sum;
    logic [7:0]       cmd;
    logic [LEN_W-1:0] len;
    logic [15:0]      first_two;
  } frame_rec_t;

endpackage

`default_nettype wire

/* sv/fcr_ifs.sv */
// Valid/ready channel interfaces for received bytes and frame events.
// Depends on fcr_pkg.
`default_nettype none

interface fcr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fcr_event_if;
  logic                     valid;
  logic                     ready;
  logic [2:0]               event_res;
  logic [7:0]               command_code;
  logic [fcr_pkg::LEN_W-1:0] payload_length;
  logic signed [15:0]       target_tenths;

  modport source (output valid, output event_res, output command_code,
                  output payload_length, output target_tenths, input ready);
  modport sink   (input valid, input event_res, input command_code,
                  input payload_length, input target_tenths, output ready);
endinterface

`default_nettype wire

/* sv/framed_command_receiver.sv */
// Top level of the framed command receiver: limit registers, parser, queue, executor.
// Depends on fcr_pkg, fcr_ifs, fcr_front, fcr_queue and fcr_back.
`default_nettype none

// Takes one serial byte per request on in_ch and assembles frames of the form
// 0xAA, command, length N, N payload bytes, XOR checksum. Every frame that
// reaches its checksum byte gives exactly one request on out_ch: bad checksum,
// move (target clamped to the limit registers), stop, unknown command, or move
// with a payload under two bytes. Idle noise and frames whose length would
// exceed 24 bytes give nothing. The block takes one byte per clock while the
// record queue is not full; the parser's running XOR and position counter are
// the per-byte loop. A result reaches out_ch through the record queue and then
// the output register, and a two-entry record queue plus the output register
// absorb consumer stalls, so in_ch only holds ready low when both queue entries
// are occupied. Write the limit registers (index 0 upper, 1 lower, signed
// tenths of a degree) while idle.

module framed_command_receiver (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  fcr_byte_if.sink               in_ch,
  fcr_event_if.source            out_ch,
  input  wire logic              cfg_we_i,
  input  fcr_pkg::cfg_idx_t      cfg_idx_i,
  input  wire logic [15:0]       cfg_data_i
);
  import fcr_pkg::*;

  logic [15:0] upper_q;
  logic [15:0] lower_q;

  logic       push;
  frame_rec_t rec_in;
  frame_rec_t rec_out;
  logic       q_nonempty;
  logic       q_full;
  logic       pop;

  // Limit registers: hold until written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= UPPER_RESET;
      lower_q <= LOWER_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_UPPER) upper_q <= cfg_data_i;
      if (cfg_idx_i == CFG_LOWER) lower_q <= cfg_data_i;
    end
  end

  // Front: classify bytes, push one record per completed frame.
  fcr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .full_i (q_full),
    .push_o (push),
    .rec_o  (rec_in)
  );

  // Decouple parser from the consumer.
  fcr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rec_i      (rec_in),
    .pop_i      (pop),
    .rec_o      (rec_out),
    .nonempty_o (q_nonempty),
    .full_o     (q_full)
  );

  // Back: decode, clamp, drive the result register.
  fcr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rec_i   (rec_out),
    .avail_i (q_nonempty),
    .pop_o   (pop),
    .upper_i (upper_q),
    .lower_i (lower_q),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

/* sv/fcr_front.sv */
// Byte parser: tracks frame position and running XOR, emits one record per completed frame.
// Depends on fcr_pkg and fcr_ifs.
`default_nettype none

module fcr_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  fcr_byte_if.sink          in_ch,
  input  wire logic         full_i,
  output logic              push_o,
  output fcr_pkg::frame_rec_t rec_o
);
  import fcr_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] total_q, total_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       xor_q, xor_d;
  logic [15:0]      p2_q, p2_d;

  logic       take;
  logic [7:0] b;
  logic       too_long;
  logic       last_byte;

  assign in_ch.ready = !full_i;
  assign take        = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;

  assign too_long  = ({1'b0, b} + 9'(HDR_BYTES)) > 9'(MAX_FRAME_BYTES);
  assign last_byte = ({1'b0, pos_q} + (POS_W+1)'(1)) >= {1'b0, total_q};

  always_comb begin
    pos_d   = pos_q;
    total_d = total_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    xor_d   = xor_q;
    p2_d    = p2_q;
    push_o  = 1'b0;
    if (take) begin
      priority if (pos_q == POS_W'(0)) begin
        if (b == START_BYTE) begin
          xor_d = b;
          pos_d = POS_W'(1);
        end
      end else if (pos_q == POS_W'(1)) begin
        cmd_d = b;
        xor_d = xor_q ^ b;
        pos_d = POS_W'(2);
      end else if (pos_q == POS_W'(2)) begin
        if (too_long) begin
          // drop the frame without a report
          pos_d = '0;
        end else begin
          len_d   = b[LEN_W-1:0];
          total_d = POS_W'(b) + POS_W'(HDR_BYTES);
          xor_d   = xor_q ^ b;
          p2_d    = '0;
          pos_d   = POS_W'(3);
        end
      end else if (last_byte) begin
        push_o = 1'b1;
        pos_d  = '0;
      end else begin
        if (pos_q == POS_W'(3)) p2_d[15:8] = b;
        if (pos_q == POS_W'(4)) p2_d[7:0]  = b;
        xor_d = xor_q ^ b;
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_comb begin
    rec_o.bad_sum   = (xor_q != b);
    rec_o.cmd       = cmd_q;
    rec_o.len       = len_q;
    rec_o.first_two = p2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    cmd_q   <= cmd_d;
    len_q   <= len_d;
    xor_q   <= xor_d;
    p2_q    <= p2_d;
  end

endmodule

`default_nettype wire

/* sv/fcr_queue.sv */
// Short FIFO of frame records between the parser and the executor.
// Depends on fcr_pkg.
`default_nettype none

module fcr_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  fcr_pkg::frame_rec_t rec_i,
  input  wire logic           pop_i,
  output fcr_pkg::frame_rec_t rec_o,
  output logic                nonempty_o,
  output logic                full_o
);
  import fcr_pkg::*;

  frame_rec_t        slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign nonempty_o = (cnt_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;
  assign rec_o      = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) cnt_d = cnt_q + QCNT_W'(1);
    if (do_pop && !do_push) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= rec_i;
  end

endmodule

`default_nettype wire

/* sv/fcr_back.sv */
// Executor: decodes a frame record, clamps the move target, drives the event register.
// Depends on fcr_pkg and fcr_ifs.
`default_nettype none

module fcr_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  fcr_pkg::frame_rec_t rec_i,
  input  wire logic           avail_i,
  output logic                pop_o,
  input  wire logic [15:0]    upper_i,
  input  wire logic [15:0]    lower_i,
  fcr_event_if.source         out_ch
);
  import fcr_pkg::*;

  logic               valid_q;
  event_e             ev_q, ev_d;
  logic [7:0]         cmd_q;
  logic [LEN_W-1:0]   len_q;
  logic signed [15:0] tgt_q, tgt_d;
  logic signed [15:0] t_hi;
  logic               load;

  assign load  = avail_i && (!valid_q || out_ch.ready);
  assign pop_o = load;

  // Clamp down to the upper limit first, then up to the lower limit.
  always_comb begin
    t_hi = ($signed(rec_i.first_two) > $signed(upper_i)) ? $signed(upper_i)
                                                        : $signed(rec_i.first_two);
    if (t_hi < $signed(lower_i)) t_hi = $signed(lower_i);
  end

  always_comb begin
    tgt_d = '0;
    priority if (rec_i.bad_sum) begin
      ev_d = EV_BADSUM;
    end else if (rec_i.cmd == CMD_MOVE) begin
      if (rec_i.len < LEN_W'(2)) begin
        ev_d = EV_SHORT;
      end else begin
        ev_d  = EV_MOVE;
        tgt_d = t_hi;
      end
    end else if (rec_i.cmd == CMD_HALT) begin
      ev_d = EV_STOP;
    end else begin
      ev_d = EV_UNKNOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ev_q  <= ev_d;
      cmd_q <= rec_i.cmd;
      len_q <= rec_i.len;
      tgt_q <= tgt_d;
    end
  end

  assign out_ch.valid          = valid_q;
  assign out_ch.event_res      = ev_q;
  assign out_ch.command_code   = cmd_q;
  assign out_ch.payload_length = len_q;
  assign out_ch.target_tenths  = tgt_q;

endmodule

`default_nettype wire

/* sv/fcr_checker.sv */
// Port-level checks on the framed command receiver's event channel.
// Depends on fcr_pkg; bound to framed_command_receiver below.
`default_nettype none

module fcr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [2:0]  event_res_i,
  input wire logic [7:0]  command_code_i,
  input wire logic [fcr_pkg::LEN_W-1:0] payload_length_i,
  input wire logic [15:0] target_tenths_i
);
  import fcr_pkg::*;

  // A stalled request holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(event_res_i)
      && $stable(target_tenths_i) && $stable(command_code_i))
    else $error("event request changed while stalled");

  // Only a move carries a nonzero target.
  a_tgt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_res_i != EV_MOVE) |-> target_tenths_i == '0)
    else $error("nonzero target on a non-move event");

  // Stop and short-move events match their command byte.
  a_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_res_i == EV_STOP || event_res_i == EV_SHORT) |->
      command_code_i == (event_res_i == EV_STOP ? CMD_HALT : CMD_MOVE))
    else $error("event code disagrees with command byte");

  // Reported lengths never exceed the frame limit, and event codes stay in range.
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> {1'b0, payload_length_i} <= (LEN_W+1)'(MAX_FRAME_BYTES - HDR_BYTES)
      && event_res_i <= EV_BADSUM)
    else $error("length or event code out of range");

endmodule

bind framed_command_receiver fcr_checker u_fcr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_ch.valid),
  .out_ready_i      (out_ch.ready),
  .event_res_i      (out_ch.event_res),
  .command_code_i   (out_ch.command_code),
  .payload_length_i (out_ch.payload_length),
  .target_tenths_i  (out_ch.target_tenths)
);

`default_nettype wire
